>>> rtl/skew_line_midpoint_core_defines.svh
// ----------------------------------------------------------------------------
// skew_line_midpoint_core assertion macros
// shared assertion forms, clocked on clk_i and quiet while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef SKEW_LINE_MIDPOINT_CORE_DEFINES_SVH
`define SKEW_LINE_MIDPOINT_CORE_DEFINES_SVH

// same-cycle implication
`define SLM_ASSERT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/slm_pkg.sv
// ----------------------------------------------------------------------------
// slm_pkg
// item types, field widths and status codes of the skew line midpoint core
// ----------------------------------------------------------------------------
package slm_pkg;

  localparam int COORD_WIDTH  = 32;
  localparam int DIR_WIDTH    = 16;
  localparam int LIMIT_WIDTH  = 32;
  localparam int STATUS_WIDTH = 2;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK       = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_PARALLEL = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_SAT      = 2'd2;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] first_origin_x;
    logic signed [COORD_WIDTH-1:0] first_origin_y;
    logic signed [COORD_WIDTH-1:0] first_origin_z;
    logic signed [DIR_WIDTH-1:0]   first_dir_x;
    logic signed [DIR_WIDTH-1:0]   first_dir_y;
    logic signed [DIR_WIDTH-1:0]   first_dir_z;
    logic signed [COORD_WIDTH-1:0] second_origin_x;
    logic signed [COORD_WIDTH-1:0] second_origin_y;
    logic signed [COORD_WIDTH-1:0] second_origin_z;
    logic signed [DIR_WIDTH-1:0]   second_dir_x;
    logic signed [DIR_WIDTH-1:0]   second_dir_y;
    logic signed [DIR_WIDTH-1:0]   second_dir_z;
  } in_item_t;

  typedef struct packed {
    logic signed [COORD_WIDTH-1:0] mid_x;
    logic signed [COORD_WIDTH-1:0] mid_y;
    logic signed [COORD_WIDTH-1:0] mid_z;
    logic [STATUS_WIDTH-1:0]       status;
  } out_item_t;

endpackage

>>> rtl/skew_line_midpoint_core.sv
// ----------------------------------------------------------------------------
// skew_line_midpoint_core
// midpoint of the shortest segment between two 3d lines, fully pipelined
// ----------------------------------------------------------------------------
// Input channel in_valid_i / in_stall_o carries one line pair per item; the
// output channel out_valid_o / out_stall_i returns one midpoint item per pair,
// in order. The parallel limit is written through cfg_valid_i / cfg_ready_o
// (always ready) and should only change while no item is in flight.
// Pipeline: ten arithmetic stages, a one-bit-per-stage divider of
// COORD_WIDTH + 2 stages, and the output register.
// Throughput: one item per cycle unless frozen; each stage holds its own item.
// Stall: a skid register behind the output register catches the item leaving
// the pipeline while out_stall_i is high; once it is full the whole pipeline
// freezes and in_stall_o rises, so nothing is dropped or repeated.
// Reset: rst_ni clears all valid bits, the skid flag and the limit (to zero);
// the block takes items in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "skew_line_midpoint_core_defines.svh"

module skew_line_midpoint_core (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [slm_pkg::LIMIT_WIDTH-1:0] cfg_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  slm_pkg::in_item_t        in_item_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output slm_pkg::out_item_t       out_item_o
);

  import slm_pkg::*;

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = DIR_WIDTH;
  localparam int WW   = CW + 1;
  localparam int DPW  = 2 * DW;
  localparam int CXW  = 2 * DW + 1;
  localparam int CSW  = 2 * CXW;
  localparam int CCW  = 2 * CXW + 2;
  localparam int XPW  = WW + DW;
  localparam int XW   = XPW + 1;
  localparam int MXW  = XW + CXW;
  localparam int NW   = MXW + 2;
  localparam int CSSW = CCW + WW;
  localparam int DNW  = NW + DW;
  localparam int UW   = ((CSSW > DNW) ? CSSW : DNW) + 2;
  localparam int DENW = CCW;
  localparam int NST  = 10;
  localparam int DLAT = CW + 2;

  logic en;
  logic [LIMIT_WIDTH-1:0] limit_q;
  logic [NST-1:0]  sv_q;
  logic [DLAT-1:0] dv_q, pd_q;

  logic signed [CW-1:0] o1 [3], o2 [3];
  logic signed [DW-1:0] d1 [3], d2 [3];

  // stage 1
  logic signed [DPW-1:0] dp_q [6];
  logic signed [WW-1:0]  w1_q [3], s1_q [3];
  logic signed [DW-1:0]  d1_1_q [3], d2_1_q [3];
  // stage 2
  logic signed [CXW-1:0] c2_q [3];
  logic signed [WW-1:0]  w2_q [3], s2_q [3];
  logic signed [DW-1:0]  d1_2_q [3], d2_2_q [3];
  // stage 3
  logic signed [CSW-1:0] cs3_q [3];
  logic signed [XPW-1:0] xp1_q [6], xp2_q [6];
  logic signed [CXW-1:0] c3_q [3];
  logic signed [WW-1:0]  s3_q [3];
  logic signed [DW-1:0]  d1_3_q [3], d2_3_q [3];
  // stage 4
  logic signed [CCW-1:0] cc4_q;
  logic signed [XW-1:0]  x1_q [3], x2_q [3];
  logic signed [CXW-1:0] c4_q [3];
  logic signed [WW-1:0]  s4_q [3];
  logic signed [DW-1:0]  d1_4_q [3], d2_4_q [3];
  // stages 5 to 9
  logic                  par5_q, par6_q, par7_q, par8_q, par9_q, par10_q;
  logic signed [CCW-1:0] cc5_q, cc6_q, cc7_q, cc8_q, cc9_q;
  logic signed [DW-1:0]  d1_5_q [3], d2_5_q [3], d1_6_q [3], d2_6_q [3];
  logic signed [DW-1:0]  d1_7_q [3], d2_7_q [3];
  logic signed [MXW-1:0] mcx1 [3], mcx2 [3];
  logic signed [CSSW-1:0] mccs [3], ccs7_q [3], ccs8_q [3], ccs9_q [3];
  logic signed [NW-1:0]  n1_q, n2_q;
  logic signed [DNW-1:0] dn1 [3], dn2 [3];
  // stage 10
  logic signed [UW-1:0]  num_q [3];
  logic [DENW-1:0]       den_q;

  logic signed [CW-1:0]  quo [3];
  logic [2:0]            sat;

  out_item_t last_item, out_q, skid_q;
  logic      last_v, out_free, out_valid_q, skid_v_q;

  assign en          = !skid_v_q;
  assign in_stall_o  = skid_v_q;
  assign cfg_ready_o = 1'b1;

  always_comb begin
    o1[0] = in_item_i.first_origin_x;  o1[1] = in_item_i.first_origin_y;
    o1[2] = in_item_i.first_origin_z;
    o2[0] = in_item_i.second_origin_x; o2[1] = in_item_i.second_origin_y;
    o2[2] = in_item_i.second_origin_z;
    d1[0] = in_item_i.first_dir_x;     d1[1] = in_item_i.first_dir_y;
    d1[2] = in_item_i.first_dir_z;
    d2[0] = in_item_i.second_dir_x;    d2[1] = in_item_i.second_dir_y;
    d2[2] = in_item_i.second_dir_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sv_q <= '0;
      dv_q <= '0;
    end else if (en) begin
      sv_q <= {sv_q[NST-2:0], in_valid_i};
      dv_q <= {dv_q[DLAT-2:0], sv_q[NST-1]};
    end
  end

  // cross products c = d1 x d2, x1 = w x d1, x2 = w x d2
  always_ff @(posedge clk_i) begin
    if (en) begin
      dp_q[0] <= d1[1] * d2[2];
      dp_q[1] <= d1[2] * d2[1];
      dp_q[2] <= d1[2] * d2[0];
      dp_q[3] <= d1[0] * d2[2];
      dp_q[4] <= d1[0] * d2[1];
      dp_q[5] <= d1[1] * d2[0];
      for (int k = 0; k < 3; k++) begin
        w1_q[k]   <= WW'(o2[k]) - WW'(o1[k]);
        s1_q[k]   <= WW'(o2[k]) + WW'(o1[k]);
        d1_1_q[k] <= d1[k];
        d2_1_q[k] <= d2[k];
      end

      c2_q[0] <= CXW'(dp_q[0]) - CXW'(dp_q[1]);
      c2_q[1] <= CXW'(dp_q[2]) - CXW'(dp_q[3]);
      c2_q[2] <= CXW'(dp_q[4]) - CXW'(dp_q[5]);
      w2_q    <= w1_q;
      s2_q    <= s1_q;
      d1_2_q  <= d1_1_q;
      d2_2_q  <= d2_1_q;

      for (int k = 0; k < 3; k++) begin
        cs3_q[k] <= c2_q[k] * c2_q[k];
      end
      xp1_q[0] <= w2_q[1] * d1_2_q[2];
      xp1_q[1] <= w2_q[2] * d1_2_q[1];
      xp1_q[2] <= w2_q[2] * d1_2_q[0];
      xp1_q[3] <= w2_q[0] * d1_2_q[2];
      xp1_q[4] <= w2_q[0] * d1_2_q[1];
      xp1_q[5] <= w2_q[1] * d1_2_q[0];
      xp2_q[0] <= w2_q[1] * d2_2_q[2];
      xp2_q[1] <= w2_q[2] * d2_2_q[1];
      xp2_q[2] <= w2_q[2] * d2_2_q[0];
      xp2_q[3] <= w2_q[0] * d2_2_q[2];
      xp2_q[4] <= w2_q[0] * d2_2_q[1];
      xp2_q[5] <= w2_q[1] * d2_2_q[0];
      c3_q    <= c2_q;
      s3_q    <= s2_q;
      d1_3_q  <= d1_2_q;
      d2_3_q  <= d2_2_q;

      cc4_q <= CCW'(cs3_q[0]) + CCW'(cs3_q[1]) + CCW'(cs3_q[2]);
      for (int k = 0; k < 3; k++) begin
        x1_q[k] <= XW'(xp1_q[2*k]) - XW'(xp1_q[2*k+1]);
        x2_q[k] <= XW'(xp2_q[2*k]) - XW'(xp2_q[2*k+1]);
      end
      c4_q   <= c3_q;
      s4_q   <= s3_q;
      d1_4_q <= d1_3_q;
      d2_4_q <= d2_3_q;

      par5_q <= $unsigned(cc4_q) <= CCW'(limit_q);
      cc5_q  <= cc4_q;
      d1_5_q <= d1_4_q;
      d2_5_q <= d2_4_q;

      par6_q <= par5_q;
      cc6_q  <= cc5_q;
      d1_6_q <= d1_5_q;
      d2_6_q <= d2_5_q;

      n1_q   <= NW'(mcx2[0]) + NW'(mcx2[1]) + NW'(mcx2[2]);
      n2_q   <= NW'(mcx1[0]) + NW'(mcx1[1]) + NW'(mcx1[2]);
      ccs7_q <= mccs;
      par7_q <= par6_q;
      cc7_q  <= cc6_q;
      d1_7_q <= d1_6_q;
      d2_7_q <= d2_6_q;

      ccs8_q <= ccs7_q;
      par8_q <= par7_q;
      cc8_q  <= cc7_q;
      ccs9_q <= ccs8_q;
      par9_q <= par8_q;
      cc9_q  <= cc8_q;

      // numerator over 2|c|^2: |c|^2 (o1+o2) + d1 n1 + d2 n2
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= UW'(ccs9_q[k]) + UW'(dn1[k]) + UW'(dn2[k]);
      end
      den_q   <= {cc9_q[DENW-2:0], 1'b0};
      par10_q <= par9_q;

      pd_q <= {pd_q[DLAT-2:0], par10_q};
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_lane
    slm_mul #(.AW(XW), .BW(CXW)) u_mul_cx1 (
      .clk_i(clk_i), .en_i(en), .a_i(x1_q[k]), .b_i(c4_q[k]), .p_o(mcx1[k])
    );
    slm_mul #(.AW(XW), .BW(CXW)) u_mul_cx2 (
      .clk_i(clk_i), .en_i(en), .a_i(x2_q[k]), .b_i(c4_q[k]), .p_o(mcx2[k])
    );
    slm_mul #(.AW(CCW), .BW(WW)) u_mul_ccs (
      .clk_i(clk_i), .en_i(en), .a_i(cc4_q), .b_i(s4_q[k]), .p_o(mccs[k])
    );
    slm_mul #(.AW(NW), .BW(DW)) u_mul_dn1 (
      .clk_i(clk_i), .en_i(en), .a_i(n1_q), .b_i(d1_7_q[k]), .p_o(dn1[k])
    );
    slm_mul #(.AW(NW), .BW(DW)) u_mul_dn2 (
      .clk_i(clk_i), .en_i(en), .a_i(n2_q), .b_i(d2_7_q[k]), .p_o(dn2[k])
    );
    slm_div #(.UW(UW), .DENW(DENW), .QW(CW)) u_div (
      .clk_i(clk_i), .en_i(en), .num_i(num_q[k]), .den_i(den_q),
      .quo_o(quo[k]), .sat_o(sat[k])
    );
  end

  assign last_v = dv_q[DLAT-1];

  always_comb begin
    if (pd_q[DLAT-1]) begin
      last_item.mid_x  = '0;
      last_item.mid_y  = '0;
      last_item.mid_z  = '0;
      last_item.status = STATUS_PARALLEL;
    end else begin
      last_item.mid_x  = quo[0];
      last_item.mid_y  = quo[1];
      last_item.mid_z  = quo[2];
      last_item.status = (|sat) ? STATUS_SAT : STATUS_OK;
    end
  end

  // output register with a skid stage behind it
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_v_q    <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= skid_v_q || last_v;
      skid_v_q    <= 1'b0;
    end else if (last_v && !skid_v_q) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_q <= skid_v_q ? skid_q : last_item;
    end else if (!skid_v_q) begin
      skid_q <= last_item;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `SLM_ASSERT(a_skid_behind_out, skid_v_q, out_valid_q, "skid holds an item while output is empty")
  `SLM_ASSERT(a_parallel_zero, out_valid_q && out_q.status == STATUS_PARALLEL, out_q.mid_x == '0 && out_q.mid_y == '0 && out_q.mid_z == '0, "parallel item with nonzero midpoint")
  `SLM_ASSERT_NEXT(a_frozen_hold, !en, $stable(sv_q) && $stable(dv_q), "pipeline moved while frozen")

endmodule

>>> rtl/slm_mul.sv
// ----------------------------------------------------------------------------
// slm_mul
// two-stage signed multiplier, wide operand cut into 32-bit chunks
// ----------------------------------------------------------------------------
module slm_mul #(
  parameter int AW = 64,
  parameter int BW = 32
) (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int NCH = (AW + 31) / 32;
  localparam int TW  = AW - 32 * (NCH - 1);
  localparam int PPW = 33 + BW;
  localparam int PW  = AW + BW;

  logic signed [32:0]    ch [NCH];
  logic signed [PPW-1:0] pp_d [NCH];
  logic signed [PPW-1:0] pp_q [NCH];
  logic signed [PW-1:0]  p_d, p_q;

  // lower chunks are unsigned, the top chunk carries the sign
  for (genvar k = 0; k < NCH; k++) begin : g_chunk
    if (k < NCH - 1) begin : g_low
      assign ch[k] = {1'b0, a_i[32*k +: 32]};
    end else begin : g_top
      assign ch[k] = {{(33-TW){a_i[AW-1]}}, a_i[AW-1 -: TW]};
    end
    assign pp_d[k] = ch[k] * b_i;
  end

  always_comb begin
    p_d = '0;
    for (int k = 0; k < NCH; k++) begin
      p_d = p_d + (PW'(pp_q[k]) <<< (32 * k));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NCH; k++) begin
        pp_q[k] <= pp_d[k];
      end
      p_q <= p_d;
    end
  end

  assign p_o = p_q;

endmodule

>>> rtl/slm_div.sv
// ----------------------------------------------------------------------------
// slm_div
// pipelined restoring divider, one quotient bit per stage, rounds half away
// from zero and saturates to the signed result range
// ----------------------------------------------------------------------------
module slm_div #(
  parameter int UW   = 103,
  parameter int DENW = 68,
  parameter int QW   = 32
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [UW-1:0]   num_i,
  input  logic [DENW-1:0]        den_i,
  output logic signed [QW-1:0]   quo_o,
  output logic                   sat_o
);

  localparam int CWID = (UW > DENW + QW) ? UW : DENW + QW;

  logic            neg;
  logic [UW-1:0]   mag;
  logic [CWID-1:0] wide_mag, wide_den, wide_hi;
  logic            ovf;

  logic [DENW-1:0] rem_q [QW+1];
  logic [QW-1:0]   lo_q  [QW+1];
  logic [QW-1:0]   quo_q [QW+1];
  logic [DENW-1:0] den_q [QW+1];
  logic [QW:0]     neg_q, ovf_q;

  logic            rnd, sat_d;
  logic [QW:0]     qr, bound, qs, res;
  logic signed [QW-1:0] quo_d, quo_out_q;
  logic            sat_q;

  always_comb begin
    neg      = num_i[UW-1];
    mag      = neg ? (~num_i + 1'b1) : num_i;
    wide_mag = CWID'(mag);
    wide_den = CWID'(den_i) << QW;
    ovf      = wide_mag >= wide_den;
    wide_hi  = wide_mag >> QW;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= wide_hi[DENW-1:0];
      lo_q[0]  <= mag[QW-1:0];
      quo_q[0] <= '0;
      den_q[0] <= den_i;
      neg_q[0] <= neg;
      ovf_q[0] <= ovf;
    end
  end

  for (genvar i = 1; i <= QW; i++) begin : g_step
    logic [DENW:0]   t, diff;
    logic            ge;
    logic [DENW-1:0] rem_d;

    always_comb begin
      t     = {rem_q[i-1], lo_q[i-1][QW-1]};
      diff  = t - {1'b0, den_q[i-1]};
      ge    = t >= {1'b0, den_q[i-1]};
      rem_d = ge ? diff[DENW-1:0] : t[DENW-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[i] <= rem_d;
        lo_q[i]  <= {lo_q[i-1][QW-2:0], 1'b0};
        quo_q[i] <= {quo_q[i-1][QW-2:0], ge};
        den_q[i] <= den_q[i-1];
        neg_q[i] <= neg_q[i-1];
        ovf_q[i] <= ovf_q[i-1];
      end
    end
  end

  always_comb begin
    rnd   = {rem_q[QW], 1'b0} >= {1'b0, den_q[QW]};
    qr    = {1'b0, quo_q[QW]} + (QW+1)'(rnd);
    bound = neg_q[QW] ? ((QW+1)'(1) << (QW - 1))
                      : (((QW+1)'(1) << (QW - 1)) - (QW+1)'(1));
    sat_d = ovf_q[QW] || (qr > bound);
    qs    = sat_d ? bound : qr;
    res   = neg_q[QW] ? (~qs + 1'b1) : qs;
    quo_d = res[QW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      quo_out_q <= quo_d;
      sat_q     <= sat_d;
    end
  end

  assign quo_o = quo_out_q;
  assign sat_o = sat_q;

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// skew line midpoint core testbench
// feeds line pairs under random bursts, gaps and output stalls, predicts each
// midpoint with exact wide integer arithmetic and checks results in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import slm_pkg::*;

  typedef logic signed [255:0] wide_t;

  class midpoint_board;
    logic [LIMIT_WIDTH-1:0] parallel_limit;
    out_item_t              pending_mids[$];
    int                     mismatches;

    function new();
      parallel_limit = '0;
      mismatches     = 0;
    endfunction

    function automatic void cross3(input wide_t a[3], input wide_t b[3],
                                   output wide_t r[3]);
      r[0] = a[1] * b[2] - a[2] * b[1];
      r[1] = a[2] * b[0] - a[0] * b[2];
      r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    function automatic wide_t dot3(input wide_t a[3], input wide_t b[3]);
      return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
    endfunction

    function automatic out_item_t midpoint_of(input in_item_t p);
      wide_t     o1[3], d1[3], o2[3], d2[3], w[3], c[3], x1[3], x2[3];
      wide_t     cc, den, n1, n2, num, mag, q, r, bnd;
      wide_t     lim;
      logic      neg, sat;
      out_item_t res;
      o1[0] = p.first_origin_x;  o1[1] = p.first_origin_y;  o1[2] = p.first_origin_z;
      d1[0] = p.first_dir_x;     d1[1] = p.first_dir_y;     d1[2] = p.first_dir_z;
      o2[0] = p.second_origin_x; o2[1] = p.second_origin_y; o2[2] = p.second_origin_z;
      d2[0] = p.second_dir_x;    d2[1] = p.second_dir_y;    d2[2] = p.second_dir_z;
      for (int k = 0; k < 3; k++) w[k] = o2[k] - o1[k];
      cross3(d1, d2, c);
      cc  = dot3(c, c);
      lim = '0;
      lim[LIMIT_WIDTH-1:0] = parallel_limit;
      res = '0;
      if (cc <= lim) begin
        res.status = STATUS_PARALLEL;
        return res;
      end
      cross3(w, d2, x2);
      cross3(w, d1, x1);
      n1  = dot3(c, x2);
      n2  = dot3(c, x1);
      den = cc + cc;
      sat = 1'b0;
      for (int k = 0; k < 3; k++) begin
        num = cc * (o1[k] + o2[k]) + d1[k] * n1 + d2[k] * n2;
        neg = num < 0;
        mag = neg ? -num : num;
        q   = mag / den;
        r   = mag % den;
        // halves round away from zero
        if (r + r >= den) q = q + 1;
        bnd = (wide_t'(1) <<< (COORD_WIDTH - 1)) - (neg ? 0 : 1);
        if (q > bnd) begin
          q   = bnd;
          sat = 1'b1;
        end
        if (neg) q = -q;
        case (k)
          0: res.mid_x = q[COORD_WIDTH-1:0];
          1: res.mid_y = q[COORD_WIDTH-1:0];
          default: res.mid_z = q[COORD_WIDTH-1:0];
        endcase
      end
      res.status = sat ? STATUS_SAT : STATUS_OK;
      return res;
    endfunction

    function void note_pair(input in_item_t p);
      pending_mids.push_back(midpoint_of(p));
    endfunction

    function void check_midpoint(input out_item_t got);
      out_item_t want;
      if (pending_mids.size() == 0) begin
        $display("%0t: unexpected item %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_mids.pop_front();
      if (got.mid_x !== want.mid_x) begin
        $display("%0t: mid_x expected %h actual %h", $time, want.mid_x, got.mid_x);
        mismatches++;
      end
      if (got.mid_y !== want.mid_y) begin
        $display("%0t: mid_y expected %h actual %h", $time, want.mid_y, got.mid_y);
        mismatches++;
      end
      if (got.mid_z !== want.mid_z) begin
        $display("%0t: mid_z expected %h actual %h", $time, want.mid_z, got.mid_z);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        mismatches++;
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [LIMIT_WIDTH-1:0] cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_stall_o;
  in_item_t               in_item_i = '0;
  logic                   out_valid_o;
  logic                   out_stall_i = 1'b0;
  out_item_t              out_item_o;

  midpoint_board board = new();
  bit            hold_req = 1'b0;

  skew_line_midpoint_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) board.note_pair(in_item_i);
    if (rst_ni && out_valid_o && !out_stall_i) board.check_midpoint(out_item_o);
  end

  // receiver: stall mode changes per stretch, plus one long hold on request
  initial begin
    int mode, stretch, hold_left;
    hold_left = 0;
    forever begin
      mode    = $urandom_range(2);
      stretch = $urandom_range(5, 80);
      repeat (stretch) begin
        @(posedge clk_i);
        if (hold_req && hold_left == 0) begin
          hold_left = 300;
          hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
          hold_left--;
          out_stall_i <= 1'b1;
        end else begin
          case (mode)
            0: out_stall_i <= 1'b0;
            1: out_stall_i <= ($urandom_range(99) < 30);
            default: out_stall_i <= ($urandom_range(99) < 75);
          endcase
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("Simulation FAILED");
    $finish;
  end

  task automatic send_pair(input in_item_t p);
    in_valid_i <= 1'b1;
    in_item_i  <= p;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic idle_gap(input int cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    while (board.pending_mids.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [LIMIT_WIDTH-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    board.parallel_limit = v;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic signed [DIR_WIDTH-1:0] rand_dir(input int span);
    return DIR_WIDTH'($signed($urandom_range(2 * span)) - span);
  endfunction

  function automatic in_item_t make_pair();
    in_item_t p;
    int       kind;
    p    = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
            $urandom, $urandom, $urandom};
    kind = $urandom_range(3);
    if (kind == 1) begin
      // small origins
      p.first_origin_x  = $signed($urandom_range(2000000)) - 1000000;
      p.first_origin_y  = $signed($urandom_range(2000000)) - 1000000;
      p.first_origin_z  = $signed($urandom_range(2000000)) - 1000000;
      p.second_origin_x = $signed($urandom_range(2000000)) - 1000000;
      p.second_origin_y = $signed($urandom_range(2000000)) - 1000000;
      p.second_origin_z = $signed($urandom_range(2000000)) - 1000000;
    end else if (kind == 2) begin
      // near parallel directions
      p.second_dir_x = p.first_dir_x + rand_dir(4);
      p.second_dir_y = p.first_dir_y + rand_dir(4);
      p.second_dir_z = p.first_dir_z + rand_dir(4);
    end else if (kind == 3) begin
      // short directions
      p.first_dir_x  = rand_dir(40);
      p.first_dir_y  = rand_dir(40);
      p.first_dir_z  = rand_dir(40);
      p.second_dir_x = rand_dir(40);
      p.second_dir_y = rand_dir(40);
      p.second_dir_z = rand_dir(40);
    end
    return p;
  endfunction

  task automatic random_run(input int count, input bit with_hold);
    int sent, burst;
    bit held;
    sent = 0;
    held = 1'b0;
    while (sent < count) begin
      if (with_hold && !held && sent >= 50) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      burst = $urandom_range(1, 40);
      for (int i = 0; i < burst && sent < count; i++, sent++) send_pair(make_pair());
      if ($urandom_range(3) != 0) idle_gap($urandom_range(1, 6));
    end
    idle_gap(0);
  endtask

  initial begin
    in_item_t                  p;
    logic signed [COORD_WIDTH-1:0] cmax, cmin;
    logic signed [DIR_WIDTH-1:0]   dmax, dmin;
    cmax = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    cmin = {1'b1, {(COORD_WIDTH-1){1'b0}}};
    dmax = {1'b0, {(DIR_WIDTH-1){1'b1}}};
    dmin = {1'b1, {(DIR_WIDTH-1){1'b0}}};
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: zero directions are parallel
    send_pair('0);
    // perpendicular skew lines 131072 apart in z
    p = '0;
    p.first_dir_x = 16'sd16384;
    p.second_dir_y = 16'sd16384;
    p.second_origin_z = 32'sd131072;
    send_pair(p);
    // same lines, opposite direction signs
    p.first_dir_x = -16'sd16384;
    p.second_dir_y = dmin;
    send_pair(p);
    // closest point beyond the positive x bound
    p = '0;
    p.first_origin_x = cmax; p.first_dir_y = 16'sd1;
    p.second_origin_x = cmax; p.second_origin_z = 32'sd65536;
    p.second_dir_x = 16'sd1; p.second_dir_z = -16'sd1;
    send_pair(p);
    // and beyond the negative bound
    p.first_origin_x = cmin; p.second_origin_x = cmin; p.second_dir_x = -16'sd1;
    send_pair(p);
    // extremes everywhere
    p = {cmax, cmax, cmax, dmax, dmin, dmax, cmin, cmin, cmin, dmin, dmax, dmax};
    send_pair(p);
    p = {cmin, cmax, cmin, dmin, dmin, dmax, cmax, cmin, cmax, dmax, dmin, dmin};
    send_pair(p);
    p = {cmin, cmin, cmin, dmin, dmin, dmin, cmax, cmax, cmax, dmax, dmax, dmax};
    send_pair(p);
    p = {cmax, cmin, 32'sd1, dmax, 16'sd0, dmin, -32'sd1, cmax, cmin, 16'sd0, dmax, dmin};
    send_pair(p);
    // rounding ties: half units come from odd sums
    p = '0;
    p.first_dir_x = 16'sd1; p.second_dir_y = 16'sd1;
    p.first_origin_z = 32'sd1;
    send_pair(p);
    p.first_origin_z = -32'sd1;
    send_pair(p);
    // parallel but offset
    p = '0;
    p.first_dir_x = 16'sd100; p.second_dir_x = -16'sd200;
    p.second_origin_y = 32'sd65536;
    send_pair(p);
    for (int i = 0; i < 8; i++) send_pair(make_pair());
    idle_gap(0);
    drain();

    random_run(600, 1'b1);
    drain();

    write_limit(32'hFFFF_FFFF);
    random_run(300, 1'b0);
    drain();

    write_limit(32'd5000);
    random_run(400, 1'b0);
    drain();

    write_limit($urandom);
    random_run(300, 1'b0);
    drain();

    write_limit('0);
    random_run(200, 1'b0);
    drain();

    if (board.mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/slm_pkg.sv
rtl/slm_mul.sv
rtl/slm_div.sv
rtl/skew_line_midpoint_core.sv
tb/testbench.sv
